[rtl/bba_pkg.sv]
// Shared types and constants for the bitmap block allocator.
`default_nettype none
package bba_pkg;

  localparam int COUNT_W     = 13;
  localparam int BLOCK_W     = 12;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 1;
  localparam int COUNT_MAX   = 8191;

  localparam logic [COUNT_W-1:0] TOTAL_RESET = 13'd4096;
  localparam logic [BLOCK_W-1:0] START_RESET = 12'd0;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_TOTAL = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_START = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_SPACE = 2'd1,
    STATUS_RANGE    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOCATE,
    ST_ALLOC,
    ST_FREE,
    ST_POST
  } state_t;

endpackage
`default_nettype wire

[rtl/bba_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                                 clk,
  input  wire logic                                 wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                     wr_data,
  input  wire logic                                 rd_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

[rtl/bba_scan.sv]
// Lowest-free-bit search over one bitmap word within a bit window.
`default_nettype none
module bba_scan #(
  parameter int WORD_BITS = 64
) (
  input  wire logic [WORD_BITS-1:0]            word,
  input  wire logic [$clog2(WORD_BITS)-1:0]    lo_off,
  input  wire logic [$clog2(WORD_BITS+1)-1:0]  hi_lim,
  output logic                                 found,
  output logic [$clog2(WORD_BITS)-1:0]         idx
);

  localparam int OFF_W = $clog2(WORD_BITS);
  localparam int LIM_W = $clog2(WORD_BITS + 1);

  logic [WORD_BITS-1:0] avail;

  // a bit is a candidate when clear and inside [lo_off, hi_lim)
  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      avail[i] = !word[i] && (OFF_W'(i) >= lo_off) && (LIM_W'(i) < hi_lim);
    end
  end

  always_comb begin
    found = |avail;
    idx   = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (avail[i]) begin
        idx = OFF_W'(i);
      end
    end
  end

endmodule
`default_nettype wire

[rtl/bitmap_block_allocator.sv]
// First-fit block allocator: sequencer, counters and bitmap store.
// Steps: allocate walks to the start word, scans word by word, then posts; free walks to its
// word, clears the bit, then posts; no space and out of range post without a map access.
// Throughput: one request at a time; the word walk and scan go one map word per cycle.
// Reset: a clearing pass writes MAP_WORDS zero words (input stalled meanwhile); the
// registers return to their defaults and the free counter reloads; config writes are taken.
`default_nettype none
module bitmap_block_allocator #(
  parameter int MAX_BLOCKS    = 4096,
  parameter int MAP_WORD_BITS = 64
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [bba_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [bba_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic                                 kind,
  input  wire logic [bba_pkg::BLOCK_W-1:0]          block_number,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [1:0]                                status,
  output logic [bba_pkg::BLOCK_W-1:0]               granted_block,
  output logic [bba_pkg::COUNT_W-1:0]               free_count
);

  import bba_pkg::*;

  localparam int MAP_WORDS = (MAX_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int WIDX_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int OFF_W     = $clog2(MAP_WORD_BITS);
  localparam int LIM_W     = $clog2(MAP_WORD_BITS + 1);
  localparam int BASE_W    = COUNT_W + 1;
  localparam int CAP_INT   = (MAX_BLOCKS > COUNT_MAX) ? COUNT_MAX : MAX_BLOCKS;
  localparam logic [COUNT_W-1:0] CAP = COUNT_W'(CAP_INT);
  localparam logic [COUNT_W-1:0] COUNT_RESET = (TOTAL_RESET > CAP) ? CAP : TOTAL_RESET;
  localparam logic [BASE_W-1:0]  WORD_STEP = BASE_W'(MAP_WORD_BITS);

  state_t state, state_next;

  logic [COUNT_W-1:0] total_reg;
  logic [BLOCK_W-1:0] start_reg;
  logic [COUNT_W-1:0] free_counter;
  logic [WIDX_W-1:0]  clear_idx;
  logic [WIDX_W-1:0]  word_idx;
  logic [BASE_W-1:0]  base;
  logic [COUNT_W-1:0] target;
  logic               op_kind;
  logic [OFF_W-1:0]   lo_off;
  status_t            res_status;
  logic [BLOCK_W-1:0] res_granted;

  // map port
  logic                     rd_en, wr_en;
  logic [WIDX_W-1:0]        rd_addr, wr_addr;
  logic [MAP_WORD_BITS-1:0] wr_data, rd_data;

  // datapath helpers
  logic [COUNT_W-1:0] eff_total;
  logic               in_fire, in_reject, clear_last, out_free;
  logic [BASE_W-1:0]  base_end, target_ext, rel, lim_raw;
  logic               loc_hit, last_word, free_bit_set;
  logic [LIM_W-1:0]   hi_lim;
  logic               scan_found;
  logic [OFF_W-1:0]   scan_idx;
  logic [BASE_W-1:0]  grant_sum;

  // reload value for a config write
  logic [COUNT_W-1:0] new_total, new_eff, reload_val;
  logic [BLOCK_W-1:0] new_start;

  bba_ram #(
    .WIDTH (MAP_WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bba_scan #(
    .WORD_BITS (MAP_WORD_BITS)
  ) u_scan (
    .word   (rd_data),
    .lo_off (lo_off),
    .hi_lim (hi_lim),
    .found  (scan_found),
    .idx    (scan_idx)
  );

  always_comb begin
    eff_total  = (total_reg > CAP) ? CAP : total_reg;
    in_fire    = in_valid && (state == ST_IDLE);
    if (kind == KIND_ALLOC) begin
      in_reject = (free_counter == '0) || ({1'b0, start_reg} >= eff_total);
    end else begin
      in_reject = {1'b0, block_number} >= eff_total;
    end
    clear_last   = (clear_idx == WIDX_W'(MAP_WORDS - 1));
    out_free     = !out_valid || !out_stall;
    base_end     = base + WORD_STEP;
    target_ext   = {1'b0, target};
    loc_hit      = target_ext < base_end;
    rel          = target_ext - base;
    lim_raw      = {1'b0, eff_total} - base;
    hi_lim       = (lim_raw >= WORD_STEP) ? LIM_W'(MAP_WORD_BITS) : lim_raw[LIM_W-1:0];
    last_word    = base_end >= {1'b0, eff_total};
    free_bit_set = rd_data[lo_off];
    grant_sum    = base + BASE_W'(scan_idx);
  end

  always_comb begin
    new_total  = (cfg_index == REG_TOTAL) ? cfg_data : total_reg;
    new_start  = (cfg_index == REG_START) ? cfg_data[BLOCK_W-1:0] : start_reg;
    new_eff    = (new_total > CAP) ? CAP : new_total;
    reload_val = ({1'b0, new_start} < new_eff) ? (new_eff - {1'b0, new_start}) : '0;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) state_next = in_reject ? ST_POST : ST_LOCATE;
      end
      ST_LOCATE: begin
        if (loc_hit) state_next = (op_kind == KIND_FREE) ? ST_FREE : ST_ALLOC;
      end
      ST_ALLOC: begin
        if (scan_found || last_word) state_next = ST_POST;
      end
      ST_FREE: begin
        state_next = ST_POST;
      end
      ST_POST: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall = (state != ST_IDLE);
    rd_en    = 1'b0;
    rd_addr  = word_idx;
    wr_en    = 1'b0;
    wr_addr  = word_idx;
    wr_data  = rd_data;
    unique case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clear_idx;
        wr_data = '0;
      end
      ST_LOCATE: begin
        rd_en = loc_hit;
      end
      ST_ALLOC: begin
        if (scan_found) begin
          wr_en   = 1'b1;
          wr_data = rd_data | (MAP_WORD_BITS'(1) << scan_idx);
        end else if (!last_word) begin
          rd_en   = 1'b1;
          rd_addr = word_idx + WIDX_W'(1);
        end
      end
      ST_FREE: begin
        wr_en   = free_bit_set;
        wr_data = rd_data & ~(MAP_WORD_BITS'(1) << lo_off);
      end
      ST_IDLE, ST_POST: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_idx    <= '0;
      out_valid    <= 1'b0;
      total_reg    <= TOTAL_RESET;
      start_reg    <= START_RESET;
      free_counter <= COUNT_RESET;
    end else begin
      if (state == ST_CLEAR) begin
        clear_idx <= clear_idx + WIDX_W'(1);
      end
      if (state == ST_POST && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == ST_ALLOC && scan_found) begin
        free_counter <= free_counter - COUNT_W'(1);
      end
      if (state == ST_FREE && free_bit_set && free_counter < eff_total) begin
        free_counter <= free_counter + COUNT_W'(1);
      end
      if (cfg_we) begin
        if (cfg_index == REG_TOTAL) begin
          total_reg <= cfg_data;
        end else begin
          start_reg <= cfg_data[BLOCK_W-1:0];
        end
        free_counter <= reload_val;
      end
    end
  end

  // request datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          op_kind     <= kind;
          word_idx    <= '0;
          base        <= '0;
          res_granted <= '0;
          res_status  <= STATUS_OK;
          if (kind == KIND_ALLOC) begin
            target <= {1'b0, start_reg};
            if (in_reject) res_status <= STATUS_NO_SPACE;
          end else begin
            target <= {1'b0, block_number};
            if (in_reject) res_status <= STATUS_RANGE;
          end
        end
      end
      ST_LOCATE: begin
        if (loc_hit) begin
          lo_off <= rel[OFF_W-1:0];
        end else begin
          word_idx <= word_idx + WIDX_W'(1);
          base     <= base_end;
        end
      end
      ST_ALLOC: begin
        if (scan_found) begin
          res_granted <= grant_sum[BLOCK_W-1:0];
        end else if (last_word) begin
          res_status <= STATUS_NO_SPACE;
        end else begin
          word_idx <= word_idx + WIDX_W'(1);
          base     <= base_end;
          lo_off   <= '0;
        end
      end
      ST_POST: begin
        if (out_free) begin
          status        <= res_status;
          granted_block <= res_granted;
          free_count    <= free_counter;
        end
      end
      ST_CLEAR, ST_FREE: begin
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire
